// ----- sv/tce_pkg.sv -----
package tce_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int ADDR_W   = 11;
    localparam int DATA_W   = 16;
    localparam int IDX_W    = 1;
    localparam int CFG_W    = 8;
    localparam int OUT_W    = 40;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_TEXT_COLOR     = 1'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_TOP_ROW = 1'd1;

    localparam logic [CHAR_W-1:0] CODE_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;
    localparam logic [ROW_W-1:0]   WINDOW_TOP_RESET = 5'd2;

    typedef struct packed {
        logic              cell_write;
        logic [ADDR_W-1:0] cell_address;
        logic [DATA_W-1:0] cell_data;
        logic              clear_window_request;
        logic [ADDR_W-1:0] cursor_position;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cursor_t;

    // Linear cell index row * SCREEN_COLUMNS + column, kept to the address width.
    function automatic logic [ADDR_W-1:0] linear_index(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
        logic [ADDR_W:0] sum;
        begin
            sum = (ADDR_W+1)'(row) * (ADDR_W+1)'(SCREEN_COLUMNS) + (ADDR_W+1)'(col);
            return sum[ADDR_W-1:0];
        end
    endfunction

endpackage

// ----- sv/tce_step.sv -----
module tce_step
(
    input  logic [tce_pkg::CHAR_W-1:0]  char_code,
    input  tce_pkg::cursor_t            cursor,
    input  logic [tce_pkg::COLOR_W-1:0] text_color,
    input  logic [tce_pkg::ROW_W-1:0]   window_top_row,
    output tce_pkg::cursor_t            cursor_next,
    output tce_pkg::result_t            result
);

    logic                        clear;
    logic [tce_pkg::ROW_W-1:0]   top_sat;
    logic [tce_pkg::ROW_W-1:0]   row0;
    logic [tce_pkg::COL_W-1:0]   col0;
    logic [tce_pkg::ROW_W-1:0]   row_adv;
    logic [tce_pkg::COL_W:0]     tab_col;
    logic [tce_pkg::COL_W:0]     inc_col;
    logic [tce_pkg::ROW_W-1:0]   row_n;
    logic [tce_pkg::COL_W-1:0]   col_n;

    always_comb
    begin
        top_sat = (window_top_row >= tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS))
                ? tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS - 1) : window_top_row;
        clear   = (cursor.row >= tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS));
        row0    = clear ? top_sat : cursor.row;
        col0    = (cursor.col >= tce_pkg::COL_W'(tce_pkg::SCREEN_COLUMNS))
                ? tce_pkg::COL_W'(tce_pkg::SCREEN_COLUMNS - 1) : cursor.col;
        row_adv = (row0 < tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS)) ? row0 + 1'b1 : row0;

        // Tab rounds up to the next multiple of eight.
        tab_col = ({1'b0, col0} + (tce_pkg::COL_W+1)'(8)) & ~(tce_pkg::COL_W+1)'(7);
        inc_col = {1'b0, col0} + 1'b1;

        row_n = row0;
        col_n = col0;
        result.cell_write   = 1'b0;
        result.cell_address = '0;
        result.cell_data    = '0;

        priority if (char_code == tce_pkg::CODE_BACKSPACE && col0 != '0)
        begin
            col_n = col0 - 1'b1;
            result.cell_write   = 1'b1;
            result.cell_address = tce_pkg::linear_index(row0, col_n);
            result.cell_data    = {text_color, tce_pkg::CODE_SPACE};
        end
        else if (char_code == tce_pkg::CODE_RETURN)
        begin
            col_n = '0;
        end
        else if (char_code == tce_pkg::CODE_TAB)
        begin
            if (tab_col >= (tce_pkg::COL_W+1)'(tce_pkg::SCREEN_COLUMNS))
            begin
                row_n = row_adv;
                col_n = '0;
            end
            else
            begin
                col_n = tab_col[tce_pkg::COL_W-1:0];
            end
        end
        else if (char_code == tce_pkg::CODE_LINEFEED)
        begin
            row_n = row_adv;
            col_n = '0;
        end
        else if (char_code != tce_pkg::CODE_NUL)
        begin
            result.cell_write   = 1'b1;
            result.cell_address = tce_pkg::linear_index(row0, col0);
            result.cell_data    = {text_color, char_code};
            if (inc_col >= (tce_pkg::COL_W+1)'(tce_pkg::SCREEN_COLUMNS))
            begin
                row_n = row_adv;
                col_n = '0;
            end
            else
            begin
                col_n = inc_col[tce_pkg::COL_W-1:0];
            end
        end
        else
        begin
            // A zero byte writes nothing; the cursor stays where it is, or at the window top row after a clear.
            col_n = col0;
        end

        result.clear_window_request = clear;
        result.cursor_position      = tce_pkg::linear_index(row_n, col_n);
        cursor_next.row = row_n;
        cursor_next.col = col_n;
    end

endmodule

// ----- sv/text_console_char_engine.sv -----
// Channel   Direction  Item
// s_*       in         one character byte
// m_*       out        cell write, clear request and cursor position
// cfg_*     in         register write: 0 text_color, 1 window_top_row
//
// An accepted item is registered in the input register, moves on to the result register
// and leaves from there; one item is accepted every cycle while m_tready does not hold
// the result. The cursor is updated as an item moves from the input register
// to the result register, so the cursor update logic sets the cycle time.
// Reset clears the cursor to row 0, column 0 and loads the register defaults.
// A stall on m_tready holds the result; the input register keeps taking one more item.
module text_console_char_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tce_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] cell_write, [11:1] cell_address, [27:12] cell_data,
    // [28] clear_window_request, [39:29] cursor_position
    output logic [tce_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_we,
    input  logic [tce_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]   cfg_data
);

    logic                        in_valid_reg;
    logic [tce_pkg::CHAR_W-1:0]  in_char_reg;
    logic                        out_valid_reg;
    tce_pkg::result_t            out_result_reg;
    tce_pkg::cursor_t            cursor_reg;
    tce_pkg::cursor_t            cursor_next;
    tce_pkg::result_t            result_next;
    logic [tce_pkg::COLOR_W-1:0] text_color_reg;
    logic [tce_pkg::ROW_W-1:0]   window_top_reg;
    logic                        in_accept;
    logic                        out_load;

    assign out_load  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;

    tce_step u_step
    (
        .char_code      (in_char_reg),
        .cursor         (cursor_reg),
        .text_color     (text_color_reg),
        .window_top_row (window_top_reg),
        .cursor_next    (cursor_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cursor_reg     <= '0;
            text_color_reg <= tce_pkg::TEXT_COLOR_RESET;
            window_top_reg <= tce_pkg::WINDOW_TOP_RESET;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (out_load)
                cursor_reg <= cursor_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    tce_pkg::REG_TEXT_COLOR:     text_color_reg <= cfg_data;
                    tce_pkg::REG_WINDOW_TOP_ROW: window_top_reg <= cfg_data[tce_pkg::ROW_W-1:0];
                    default:                     text_color_reg <= text_color_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_char_reg <= s_tdata;
        if (out_load)
            out_result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.cursor_position,
                       out_result_reg.clear_window_request,
                       out_result_reg.cell_data,
                       out_result_reg.cell_address,
                       out_result_reg.cell_write};

`ifndef SYNTHESIS
    // A result without a cell write carries zero address and data.
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.cell_write
        |-> out_result_reg.cell_address == '0 && out_result_reg.cell_data == '0)
        else $error("cell fields not zero without a cell write");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg.row <= tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS))
        else $error("cursor row beyond screen bottom");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg.col < tce_pkg::COL_W'(tce_pkg::SCREEN_COLUMNS))
        else $error("cursor column beyond screen width");

    // The cursor only moves when an item passes into the result register.
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(cursor_reg))
        else $error("cursor changed without an item");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_char_reg))
        else $error("stalled input item lost");
`endif

endmodule

// ----- tb/tb_text_console_char_engine.sv -----
`timescale 1ns / 100ps

module tb_text_console_char_engine;

    import tce_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 125;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_we    = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    text_console_char_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Characters waiting to be sent and console results predicted for accepted ones.
    logic [CHAR_W-1:0] pending_chars[$];
    result_t           predicted_results[$];

    // Shadow copy of the console state and registers.
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [COLOR_W-1:0] text_color = TEXT_COLOR_RESET;
    logic [ROW_W-1:0]   window_top = WINDOW_TOP_RESET;

    bit idle_on = 1'b1;
    int error_count = 0;
    int result_count = 0;
    int stall_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] cell_index(input int row, input int col);
        int lin;
        lin = row * SCREEN_COLUMNS + col;
        return lin[ADDR_W-1:0];
    endfunction

    // Applies one character to the shadow cursor and returns the result it should produce.
    function automatic result_t console_step(input logic [CHAR_W-1:0] ch);
        result_t r;
        int row;
        int col;
        int next_tab;
        r = '0;
        row = cur_row;
        col = cur_col;
        if (row >= SCREEN_ROWS)
        begin
            row = (window_top >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : window_top;
            r.clear_window_request = 1'b1;
        end
        if (col >= SCREEN_COLUMNS)
            col = SCREEN_COLUMNS - 1;

        if (ch == CODE_BACKSPACE && col != 0)
        begin
            col--;
            r.cell_write   = 1'b1;
            r.cell_address = cell_index(row, col);
            r.cell_data    = {text_color, CODE_SPACE};
        end
        else if (ch == CODE_RETURN)
            col = 0;
        else if (ch == CODE_TAB)
        begin
            next_tab = (col + 8) & ~7;
            if (next_tab >= SCREEN_COLUMNS)
            begin
                col = 0;
                if (row < SCREEN_ROWS)
                    row++;
            end
            else
                col = next_tab;
        end
        else if (ch == CODE_LINEFEED)
        begin
            col = 0;
            if (row < SCREEN_ROWS)
                row++;
        end
        else if (ch != CODE_NUL)
        begin
            r.cell_write   = 1'b1;
            r.cell_address = cell_index(row, col);
            r.cell_data    = {text_color, ch};
            col++;
            if (col >= SCREEN_COLUMNS)
            begin
                col = 0;
                if (row < SCREEN_ROWS)
                    row++;
            end
        end

        cur_row = row[ROW_W-1:0];
        cur_col = col[COL_W-1:0];
        r.cursor_position = cell_index(row, col);
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return CHAR_W'($urandom_range(8'h20, 8'h7E));
        else if (pick < 55)
            return CODE_LINEFEED;
        else if (pick < 63)
            return CODE_TAB;
        else if (pick < 71)
            return CODE_BACKSPACE;
        else if (pick < 77)
            return CODE_RETURN;
        else if (pick < 81)
            return CODE_NUL;
        else
            return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        $display("result %0d: %s is %0h, expected %0h", result_count, what, got_val, want_val);
        error_count++;
    endtask

    // Mostly single random characters, with bursts of text that wrap lines and
    // bursts of line feeds that push the cursor to the bottom of the screen.
    task automatic load_random(input int count);
        int n;
        int run;
        int pick;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                run = $urandom_range(10, 85);
                repeat (run) pending_chars.push_back(CHAR_W'($urandom_range(8'h21, 8'hFE)));
                n += run;
            end
            else if (pick == 1)
            begin
                run = $urandom_range(5, 25);
                repeat (run) pending_chars.push_back(CODE_LINEFEED);
                n += run;
            end
            else
            begin
                pending_chars.push_back(random_char());
                n++;
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TEXT_COLOR)
            text_color = value;
        else
            window_top = value[ROW_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // Input side: predict each accepted item, then offer the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cur_row  = '0;
            cur_col  = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(console_step(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    if (idle_on && $urandom_range(0, 9) == 0)
                    begin
                        in_gap = $urandom_range(1, 6) - 1;
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= pending_chars.pop_front();
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure and comparison against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("unexpected result", int'(m_tdata[39:29]), 0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (m_tdata[0] !== want.cell_write)
                        report_mismatch("cell_write", int'(m_tdata[0]),
                                        int'(want.cell_write));
                    if (m_tdata[11:1] !== want.cell_address)
                        report_mismatch("cell_address", int'(m_tdata[11:1]),
                                        int'(want.cell_address));
                    if (m_tdata[27:12] !== want.cell_data)
                        report_mismatch("cell_data", int'(m_tdata[27:12]),
                                        int'(want.cell_data));
                    if (m_tdata[28] !== want.clear_window_request)
                        report_mismatch("clear_window_request", int'(m_tdata[28]),
                                        int'(want.clear_window_request));
                    if (m_tdata[39:29] !== want.cursor_position)
                        report_mismatch("cursor_position", int'(m_tdata[39:29]),
                                        int'(want.cursor_position));
                end
                result_count++;
            end
            if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(1, 6) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[text_console_char_engine] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // Color and top-row settings per phase; the top row covers the extremes,
        // values past the bottom that saturate, and upper bits that get masked.
        logic [CFG_W-1:0] color_plan [PHASES];
        logic [CFG_W-1:0] top_plan   [PHASES];
        logic [CHAR_W-1:0] directed  [$];
        int ph;

        color_plan = '{8'h00, 8'hFF, 8'h1E, 8'hA5, 8'h70, 8'h0F};
        top_plan   = '{8'h00, 8'h18, 8'h1F, 8'h19, 8'hEC, 8'h02};
        color_plan[4] = CFG_W'($urandom_range(0, 255));

        // Backspace at column zero is printed as a glyph, the next one erases,
        // ten tabs run past the last column and wrap to the next row.
        directed = '{8'h00, CODE_BACKSPACE, CODE_BACKSPACE, 8'hFF, 8'h80, 8'h7F, 8'h41,
                     CODE_RETURN, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB,
                     CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_TAB, CODE_LINEFEED,
                     8'h01, 8'h55, 8'hAA, CODE_BACKSPACE, CODE_TAB, 8'h00};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            pending_chars.push_back(directed[i]);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_reg(REG_TEXT_COLOR, color_plan[ph]);
            write_reg(REG_WINDOW_TOP_ROW, top_plan[ph]);
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            load_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("[text_console_char_engine] OK");
        else
            $display("[text_console_char_engine] ERROR");
        $finish;
    end

endmodule
